### hdl/lphm_pkg.sv
// ----------------------------------------------------------------------------
// Linear-probe hash map package
// Shared constants, word types and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Table geometry. The slot count must be a power of two.
  localparam int TABLE_SLOTS   = 64;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int COUNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_BYTES_MAX = 8;
  localparam int HASH_START    = 5381;

  // Fixed field widths of the words on the ports.
  localparam int KEY_W   = 64;
  localparam int KLEN_W  = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int CNT_OUT_W = 7;

  // Operation codes.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd5;

  // Input word.
  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   key_bytes;
    logic [KLEN_W-1:0]  key_length;
    logic [VALUE_W-1:0] new_value;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [VALUE_W-1:0]   found_value;
    logic [CNT_OUT_W-1:0] entry_count_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              hash_step;
    logic              probe_init;
    logic              rd_en;
    logic              advance;
    logic              write_slot;
    logic              mark_used;
    logic              capture_found;
    logic              status_en;
    logic [STAT_W-1:0] status_code;
    logic              result_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_set;
    logic zero_value;
    logic hash_done;
    logic slot_used;
    logic key_match;
    logic probes_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/linear_probe_hash_map_top.sv
// ----------------------------------------------------------------------------
// Linear-probe hash map, top level
// Open-addressing hash map with djb2 hashing and linear probing. Lookups
// return the stored value; sets update or insert, report a full table and reject a zero value.
//
//   Channel | Signals                      | Word
//   --------+------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data  | cmd, key_bytes, key_length, value
//   output  | out_valid, out_ready, out_data | status, found_value, count
//
// One operation, from one accepted word to the next, hashes the key, the key
// length being counted up to its first zero byte, and then probes slots:
// the hash takes one key byte a cycle, and each probe is a registered memory
// read followed by a compare on the read port of the slot memory. The result
// word is loaded in the cycle before the next word can be taken. A set with value
// zero is rejected in the hash state before any probe. The worst case probes every slot.
// Reset empties the table at once through the occupancy bits.
// A result waits in the output register; a new word is taken meanwhile, and
// the controller holds its next result until that register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lphm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lphm_pkg::out_item_t out_data
);

  lphm_pkg::ctrl_cmd_t cmd;
  lphm_pkg::dp_stat_t  stat;

  // Controller.
  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  lphm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A hit always carries a nonzero value, since zero is never stored.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == lphm_pkg::ST_HIT) |-> out_data.found_value != '0)
    else $error("hit word carries a zero value");

  // Any other outcome reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != lphm_pkg::ST_HIT) |-> out_data.found_value == '0)
    else $error("non-hit word carries a value");

  // The key count never exceeds the slot count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count_out <= lphm_pkg::CNT_OUT_W'(lphm_pkg::TABLE_SLOTS))
    else $error("key count above slot count");

  // Only one operation is in flight: acceptance closes the input.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after acceptance");

endmodule

### hdl/lphm_ctrl.sv
// ----------------------------------------------------------------------------
// Linear-probe hash map controller
// Sequences one operation: capture, hashing one byte a cycle, probing one
// slot at a time through a read state and a check state, and hand-over of the result word.
// ----------------------------------------------------------------------------
module lphm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lphm_pkg::dp_stat_t  stat,
  output lphm_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HASH   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.is_set && stat.zero_value) begin
          cmd.status_en   = 1'b1;
          cmd.status_code = lphm_pkg::ST_REJECTED;
          state_next      = S_FINISH;
        end else if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_READ;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.slot_used) begin
          // Empty slot ends the probe sequence.
          cmd.status_en = 1'b1;
          if (stat.is_set) begin
            cmd.write_slot  = 1'b1;
            cmd.mark_used   = 1'b1;
            cmd.status_code = lphm_pkg::ST_INSERTED;
          end else begin
            cmd.status_code = lphm_pkg::ST_MISS;
          end
          state_next = S_FINISH;
        end else if (stat.key_match) begin
          cmd.status_en = 1'b1;
          if (stat.is_set) begin
            cmd.write_slot  = 1'b1;
            cmd.status_code = lphm_pkg::ST_UPDATED;
          end else begin
            cmd.capture_found = 1'b1;
            cmd.status_code   = lphm_pkg::ST_HIT;
          end
          state_next = S_FINISH;
        end else if (stat.probes_last) begin
          // Every slot has been visited.
          cmd.status_en   = 1'b1;
          cmd.status_code = stat.is_set ? lphm_pkg::ST_FULL : lphm_pkg::ST_MISS;
          state_next      = S_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/lphm_datapath.sv
// ----------------------------------------------------------------------------
// Linear-probe hash map datapath
// Holds the current operation, the hash accumulator, the probe pointer, the
// slot memory with its occupancy bits, the key count and the result register.
// ----------------------------------------------------------------------------
module lphm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lphm_pkg::in_item_t  in_data,
  input  lphm_pkg::ctrl_cmd_t cmd,
  output lphm_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output lphm_pkg::out_item_t out_data
);

  typedef struct packed {
    logic [lphm_pkg::KEY_W-1:0]  key;
    logic [lphm_pkg::KLEN_W-1:0] klen;
  } norm_t;

  typedef struct packed {
    logic [lphm_pkg::KEY_W-1:0]   key;
    logic [lphm_pkg::KLEN_W-1:0]  klen;
    logic [lphm_pkg::VALUE_W-1:0] value;
  } slot_t;

  // Clamp the length, stop at the first zero byte and clear the rest.
  function automatic norm_t norm_key(input logic [lphm_pkg::KEY_W-1:0] b,
                                     input logic [lphm_pkg::KLEN_W-1:0] l);
    norm_t r;
    logic [lphm_pkg::KLEN_W-1:0] lim;
    logic alive;
    lim = (l > lphm_pkg::KLEN_W'(lphm_pkg::KEY_BYTES_MAX)) ?
          lphm_pkg::KLEN_W'(lphm_pkg::KEY_BYTES_MAX) : l;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < lphm_pkg::KEY_BYTES_MAX; i++) begin
      if (alive && (lphm_pkg::KLEN_W'(i) < lim) && (b[8*i +: 8] != 8'd0)) begin
        r.key[8*i +: 8] = b[8*i +: 8];
        r.klen          = lphm_pkg::KLEN_W'(i + 1);
      end else begin
        alive = 1'b0;
      end
    end
    return r;
  endfunction

  norm_t                           norm;
  logic                            op_set;
  logic [lphm_pkg::KEY_W-1:0]      key_q;
  logic [lphm_pkg::KLEN_W-1:0]     len_q;
  logic [lphm_pkg::VALUE_W-1:0]    value_q;
  logic [lphm_pkg::KLEN_W-1:0]     byte_idx;
  logic [lphm_pkg::SLOT_W-1:0]     hash;
  logic [lphm_pkg::SLOT_W-1:0]     hash_next;
  logic [lphm_pkg::SLOT_W-1:0]     byte_ext;
  logic [lphm_pkg::SLOT_W-1:0]     probe_idx;
  logic [lphm_pkg::SLOT_W-1:0]     probes;
  logic [lphm_pkg::TABLE_SLOTS-1:0] used_bits;
  logic                            used_q;
  slot_t                           mem [lphm_pkg::TABLE_SLOTS];
  slot_t                           rd_q;
  logic [lphm_pkg::COUNT_W-1:0]    count;
  logic [lphm_pkg::STAT_W-1:0]     status_q;
  logic [lphm_pkg::VALUE_W-1:0]    found_q;

  assign norm = norm_key(in_data.key_bytes, in_data.key_length);

  // One djb2 step on the slot-index bits: hash * 33 + byte.
  assign byte_ext  = lphm_pkg::SLOT_W'(key_q[8*byte_idx[2:0] +: 8]);
  assign hash_next = (hash << 5) + hash + byte_ext;

  // Status towards the controller.
  assign stat.is_set      = (op_set == lphm_pkg::CMD_SET);
  assign stat.zero_value  = (value_q == '0);
  assign stat.hash_done   = (byte_idx == len_q);
  assign stat.slot_used   = used_q;
  assign stat.key_match   = (rd_q.key == key_q) && (rd_q.klen == len_q);
  assign stat.probes_last = (probes == lphm_pkg::SLOT_W'(lphm_pkg::TABLE_SLOTS - 1));
  assign stat.out_free    = !out_valid || out_ready;

  // Operation registers, hash accumulator, probe pointer, found value and status.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_set   <= in_data.cmd;
      key_q    <= norm.key;
      len_q    <= norm.klen;
      value_q  <= in_data.new_value;
      byte_idx <= '0;
      hash     <= lphm_pkg::SLOT_W'(lphm_pkg::HASH_START);
      found_q  <= '0;
    end
    if (cmd.hash_step) begin
      hash     <= hash_next;
      byte_idx <= byte_idx + 1'b1;
    end
    if (cmd.probe_init) begin
      probe_idx <= hash;
      probes    <= '0;
    end
    if (cmd.advance) begin
      probe_idx <= probe_idx + 1'b1;
      probes    <= probes + 1'b1;
    end
    if (cmd.capture_found) begin
      found_q <= rd_q.value;
    end
    if (cmd.status_en) begin
      status_q <= cmd.status_code;
    end
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      mem[probe_idx] <= '{key: key_q, klen: len_q, value: value_q};
    end
    if (cmd.rd_en) begin
      rd_q   <= mem[probe_idx];
      used_q <= used_bits[probe_idx];
    end
  end

  // Occupancy bits and key count.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_bits <= '0;
      count     <= '0;
    end else if (cmd.mark_used) begin
      used_bits[probe_idx] <= 1'b1;
      count                <= count + 1'b1;
    end
  end

  // Result register: valid flag under reset, word loaded by the controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.status          <= status_q;
      out_data.found_value     <= found_q;
      out_data.entry_count_out <= lphm_pkg::CNT_OUT_W'(count);
    end
  end

endmodule

### tb/linear_probe_hash_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear-probe hash map testbench
// Drives lookup and set words into the hash map and checks every result word
// against a shadow copy of the table or a directed row's known word. A short
// table of directed words covers the edge cases of key handling, then a
// random run fills the table from a pool of keys until it is full and keeps
// hitting it with lookups, updates and malformed keys. Both sides idle at
// random, and the sink holds off once for a long stretch to back up the map.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top_tb;

  localparam int RANDOM_ITEMS   = 1030;
  localparam int FILL_ITEMS     = 250;
  localparam int POOL_N         = 96;
  localparam int HOLD_AT        = 600;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    lphm_pkg::in_item_t  word;
    bit                  has_known;
    lphm_pkg::out_item_t known;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lphm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lphm_pkg::out_item_t out_data;

  // Shadow copy of the table.
  bit          occupied [lphm_pkg::TABLE_SLOTS];
  logic [63:0] stored_key [lphm_pkg::TABLE_SLOTS];
  int unsigned stored_len [lphm_pkg::TABLE_SLOTS];
  logic [31:0] stored_value [lphm_pkg::TABLE_SLOTS];
  int unsigned held_count = 0;

  // Keys used by the random run.
  logic [63:0] pool_key [POOL_N];
  int unsigned pool_len [POOL_N];

  directed_row_t       directed_rows [$];
  lphm_pkg::out_item_t expected_results [$];
  int                  results_seen = 0;
  int                  error_count = 0;
  int                  stall_cycles = 0;
  bit                  quiet_in = 1'b0;
  bit                  hold_done = 1'b0;

  linear_probe_hash_map_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the shadow table and return the result it should give.
  function automatic lphm_pkg::out_item_t hash_map_apply(input lphm_pkg::in_item_t w);
    logic [63:0]         key;
    logic [31:0]         h;
    logic [7:0]          b;
    int unsigned         klen, lim, slot, i;
    lphm_pkg::out_item_t r;
    key  = '0;
    klen = 0;
    lim  = (w.key_length > lphm_pkg::KEY_BYTES_MAX) ? lphm_pkg::KEY_BYTES_MAX :
           w.key_length;
    // The key stops at its first zero byte, as a string would.
    for (i = 0; i < lim; i++) begin
      b = w.key_bytes[8*i +: 8];
      if (b == 8'd0) break;
      key[8*i +: 8] = b;
      klen++;
    end
    h = lphm_pkg::HASH_START;
    for (i = 0; i < klen; i++) h = (h << 5) + h + key[8*i +: 8];
    slot = h & (lphm_pkg::TABLE_SLOTS - 1);
    r.found_value = '0;
    if (w.cmd == lphm_pkg::CMD_SET && w.new_value == '0) begin
      r.status = lphm_pkg::ST_REJECTED;
    end else begin
      r.status = (w.cmd == lphm_pkg::CMD_SET) ? lphm_pkg::ST_FULL : lphm_pkg::ST_MISS;
      // Walk forward from the home slot, at most once round the table.
      for (i = 0; i < lphm_pkg::TABLE_SLOTS; i++) begin
        if (!occupied[slot]) begin
          if (w.cmd == lphm_pkg::CMD_SET) begin
            occupied[slot]     = 1'b1;
            stored_key[slot]   = key;
            stored_len[slot]   = klen;
            stored_value[slot] = w.new_value;
            held_count++;
            r.status = lphm_pkg::ST_INSERTED;
          end
          break;
        end else if (stored_key[slot] == key && stored_len[slot] == klen) begin
          if (w.cmd == lphm_pkg::CMD_SET) begin
            stored_value[slot] = w.new_value;
            r.status = lphm_pkg::ST_UPDATED;
          end else begin
            r.found_value = stored_value[slot];
            r.status = lphm_pkg::ST_HIT;
          end
          break;
        end
        slot = (slot + 1) % lphm_pkg::TABLE_SLOTS;
      end
    end
    r.entry_count_out = lphm_pkg::CNT_OUT_W'(held_count);
    return r;
  endfunction

  function automatic void add_row(input logic cmd, input logic [63:0] kb,
                                  input logic [3:0] kl, input logic [31:0] v,
                                  input bit has, input logic [2:0] st,
                                  input logic [31:0] fv, input logic [6:0] cnt);
    directed_row_t row;
    row.word.cmd        = cmd;
    row.word.key_bytes  = kb;
    row.word.key_length = kl;
    row.word.new_value  = v;
    row.has_known       = has;
    row.known.status          = st;
    row.known.found_value     = fv;
    row.known.entry_count_out = cnt;
    directed_rows.push_back(row);
  endfunction

  // A word for a pool key, sometimes with junk above a terminating zero or
  // with a length beyond the maximum.
  function automatic lphm_pkg::in_item_t pool_word(input logic op,
                                                   input int unsigned idx,
                                                   input logic [31:0] value);
    lphm_pkg::in_item_t w;
    int unsigned        len, j;
    len          = pool_len[idx];
    w.cmd        = op;
    w.key_bytes  = pool_key[idx];
    w.key_length = lphm_pkg::KLEN_W'(len);
    w.new_value  = value;
    if ($urandom_range(3) == 0) begin
      if (len < lphm_pkg::KEY_BYTES_MAX) begin
        for (j = len + 1; j < lphm_pkg::KEY_BYTES_MAX; j++)
          w.key_bytes[8*j +: 8] = 8'($urandom);
        w.key_length = lphm_pkg::KLEN_W'($urandom_range(15, len));
      end else begin
        w.key_length = lphm_pkg::KLEN_W'($urandom_range(15, lphm_pkg::KEY_BYTES_MAX));
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] set_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 8) return '1;
    return $urandom;
  endfunction

  // Fully random word: any command, bytes, length and value.
  function automatic lphm_pkg::in_item_t noise_word();
    lphm_pkg::in_item_t w;
    w.cmd        = 1'($urandom);
    w.key_bytes  = {$urandom, $urandom};
    w.key_length = lphm_pkg::KLEN_W'($urandom_range(15));
    w.new_value  = $urandom;
    return w;
  endfunction

  // Early on the run mostly inserts pool keys; later it mixes lookups,
  // updates and sets that find the table full.
  function automatic lphm_pkg::in_item_t random_word(input int unsigned n);
    int unsigned pick, idx;
    pick = $urandom_range(99);
    idx  = $urandom_range(POOL_N - 1);
    if (n < FILL_ITEMS) begin
      if (pick < 5) return noise_word();
      if (pick < 25) return pool_word(lphm_pkg::CMD_LOOKUP, idx, $urandom);
      return pool_word(lphm_pkg::CMD_SET, idx, set_value());
    end
    if (pick < 20) return noise_word();
    if (pick < 65) return pool_word(lphm_pkg::CMD_LOOKUP, idx, $urandom);
    return pool_word(lphm_pkg::CMD_SET, idx, set_value());
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Offer one word, wait for it to be taken and queue its expected result.
  task automatic send_word(input lphm_pkg::in_item_t w, input bit has_known,
                           input lphm_pkg::out_item_t known);
    lphm_pkg::out_item_t predicted;
    while (!quiet_in && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = hash_map_apply(w);
    expected_results.push_back(has_known ? known : predicted);
  endtask

  task automatic check_result(input lphm_pkg::out_item_t got);
    lphm_pkg::out_item_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                results_seen, got.status, want.status));
    if (got.found_value !== want.found_value)
      report_mismatch($sformatf("result %0d found_value %h, expected %h",
                                results_seen, got.found_value, want.found_value));
    if (got.entry_count_out !== want.entry_count_out)
      report_mismatch($sformatf("result %0d entry_count_out %0d, expected %0d",
                                results_seen, got.entry_count_out,
                                want.entry_count_out));
  endtask

  // Stimulus: directed table, then the random run, then drain.
  initial begin : stimulus
    int unsigned i, j;
    // The empty key, length limits and zero bytes inside the key.
    add_row(lphm_pkg::CMD_LOOKUP, 64'h0, 4'd0, 32'h0, 1,
            lphm_pkg::ST_MISS, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h61, 4'd1, 32'h0, 1,
            lphm_pkg::ST_REJECTED, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h0, 4'd0, 32'hFFFF_FFFF, 1,
            lphm_pkg::ST_INSERTED, 32'h0, 7'd1);
    add_row(lphm_pkg::CMD_LOOKUP, '1, 4'd0, 32'hFFFF_FFFF, 1,
            lphm_pkg::ST_HIT, 32'hFFFF_FFFF, 7'd1);
    add_row(lphm_pkg::CMD_SET, '1, 4'd8, 32'h1, 1,
            lphm_pkg::ST_INSERTED, 32'h0, 7'd2);
    add_row(lphm_pkg::CMD_SET, '1, 4'd15, 32'h1234_5678, 1,
            lphm_pkg::ST_UPDATED, 32'h0, 7'd2);
    add_row(lphm_pkg::CMD_LOOKUP, '1, 4'd9, 32'h0, 1,
            lphm_pkg::ST_HIT, 32'h1234_5678, 7'd2);
    add_row(lphm_pkg::CMD_LOOKUP, '1, 4'd7, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'hFFFF_FFFF_FF00_6161, 4'd8, 32'h7, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h6161, 4'd2, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h6161, 4'd1, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h6100, 4'd8, 32'h9, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h0, 4'd0, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h6161, 4'd2, 32'h0, 1,
            lphm_pkg::ST_REJECTED, 32'h0, 7'd3);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h6161, 4'd2, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h0102_0304_0506_0708, 4'd8, 32'h8000_0000, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h0102_0304_0506_0708, 4'd8, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h6161, 4'd2, 32'hFFFF_FFFF, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h80, 4'd1, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    // Single-byte keys that share a home slot, to build a probe chain.
    add_row(lphm_pkg::CMD_SET, 64'h01, 4'd1, 32'h11, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h41, 4'd1, 32'h22, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_SET, 64'h81, 4'd1, 32'h33, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'hC1, 4'd1, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);
    add_row(lphm_pkg::CMD_LOOKUP, 64'h81, 4'd1, 32'h0, 0,
            lphm_pkg::ST_HIT, 32'h0, 7'd0);

    // Pool of keys with nonzero bytes; more keys than slots, so the table fills.
    for (i = 0; i < POOL_N; i++) begin
      pool_len[i] = $urandom_range(lphm_pkg::KEY_BYTES_MAX);
      pool_key[i] = '0;
      for (j = 0; j < pool_len[i]; j++) pool_key[i][8*j +: 8] = 8'($urandom_range(255, 1));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send_word(directed_rows[k].word, directed_rows[k].has_known, directed_rows[k].known);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_in = (i >= 400 && i < 550);
      send_word(random_word(i), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result sink: checks each word and applies random and long back-pressure.
  initial begin : result_sink
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result(out_data);
      // One long hold-off so that the map backs up and stalls its input.
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= (results_seen >= 300 && results_seen < 450) ||
                   ($urandom_range(99) >= 9);
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
